FILE: hdl/bitbang_serial_master_top_assert.svh
// assertion macros used by the serial master datapath
`ifndef BITBANG_SERIAL_MASTER_TOP_ASSERT_SVH
`define BITBANG_SERIAL_MASTER_TOP_ASSERT_SVH

// same-cycle implication, held off during reset
`define BSM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bsm check failed");

// next-cycle implication, held off during reset
`define BSM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bsm check failed");

`endif

FILE: hdl/bsm_pkg.sv
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared types and constants of the bit-bang serial master.
// ----------------------------------------------------------------------------
`default_nettype none

package bsm_pkg;

    // widths of the command fields and registers
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned OP_W    = 4;
    localparam int unsigned CNT_W   = 6;
    localparam int unsigned IDX_W   = 5;
    localparam int unsigned CFG_W   = 6;
    localparam int unsigned CFGA_W  = 2;

    // largest transfer length in bits
    localparam logic [CNT_W-1:0] MAX_BITS = 6'd32;

    // command codes
    typedef enum logic [OP_W-1:0] {
        OP_START  = 4'd0,
        OP_STOP   = 4'd1,
        OP_XFER   = 4'd2,
        OP_WRITE  = 4'd3,
        OP_READ   = 4'd4,
        OP_RDBIT  = 4'd5,
        OP_WRBIT  = 4'd6,
        OP_TICKS  = 4'd7,
        OP_DATA   = 4'd8,
        OP_CLK    = 4'd9,
        OP_CS     = 4'd10,
        OP_SAMPLE = 4'd11
    } t_opcode;

    // configuration register indexes
    typedef enum logic [CFGA_W-1:0] {
        CFG_BIT_COUNT  = 2'd0,
        CFG_THREE_WIRE = 2'd1,
        CFG_SPEED      = 2'd2,
        CFG_OPEN_DRAIN = 2'd3
    } t_cfg_index;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_bsm_cmd;

    // datapath to controller status
    typedef struct packed {
        logic done;
        logic out_free;
    } t_bsm_sts;

endpackage

`default_nettype wire

FILE: hdl/bsm_ctrl.sv
// ----------------------------------------------------------------------------
// bsm_ctrl
// Command sequencer: accepts a command, runs the bit loop, commits the result.
// ----------------------------------------------------------------------------
`default_nettype none

module bsm_ctrl (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    input  wire bsm_pkg::t_bsm_sts i_sts,
    output bsm_pkg::t_bsm_cmd      o_cmd
);
    import bsm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_SHIFT = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    // command decode and next state
    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        o_cmd      = '0;
        n_state    = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (!i_sts.done) begin
                    o_cmd.step = 1'b1;
                end else if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/bsm_dpath.sv
// ----------------------------------------------------------------------------
// bsm_dpath
// Datapath: config registers, sample shifter, line state and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bsm_dpath (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_wr_en,
    input  wire [bsm_pkg::CFGA_W-1:0]    i_cfg_index,
    input  wire [bsm_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire [bsm_pkg::OP_W-1:0]      i_opcode,
    input  wire [bsm_pkg::DATA_W-1:0]    i_operand_value,
    input  wire [bsm_pkg::DATA_W-1:0]    i_line_samples,
    input  wire                          i_out_ready,
    input  wire bsm_pkg::t_bsm_cmd       i_cmd,
    output bsm_pkg::t_bsm_sts            o_sts,
    output logic                         o_out_valid,
    output logic [bsm_pkg::DATA_W-1:0]   o_read_data,
    output logic                         o_clock_level,
    output logic                         o_data_level,
    output logic                         o_select_level,
    output logic                         o_data_released
);
    import bsm_pkg::*;

    `include "bitbang_serial_master_top_assert.svh"

    // configuration
    logic [CNT_W-1:0]  r_bit_count;
    logic              r_three_wire;

    // command held during the bit loop
    t_opcode           r_op;
    logic [DATA_W-1:0] r_val;
    logic [DATA_W-1:0] r_smp;
    logic [DATA_W-1:0] r_word;
    logic [CNT_W-1:0]  r_left;
    logic [CNT_W-1:0]  n_left;
    logic [CNT_W-1:0]  w_eff;
    logic [IDX_W-1:0]  w_idx;

    // line state
    logic r_clk_line, r_dat_line, r_sel_line, r_dat_in;
    logic n_clk_line, n_dat_line, n_sel_line, n_dat_in;

    // result register
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;

    // configuration writes; speed and drive mode leave logical levels alone
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_count  <= 6'd8;
            r_three_wire <= 1'b1;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_BIT_COUNT:  r_bit_count  <= i_cfg_data;
                CFG_THREE_WIRE: r_three_wire <= i_cfg_data[0];
                CFG_SPEED:      ;
                CFG_OPEN_DRAIN: ;
                default:        ;
            endcase
        end
    end

    // transfer length clamped into one to max bits
    always_comb begin
        if (r_bit_count == '0) begin
            w_eff = 6'd1;
        end else if (r_bit_count > MAX_BITS) begin
            w_eff = MAX_BITS;
        end else begin
            w_eff = r_bit_count;
        end
    end

    // bits to sample for the incoming command
    always_comb begin
        case (t_opcode'(i_opcode))
            OP_XFER, OP_READ:    n_left = w_eff;
            OP_RDBIT, OP_SAMPLE: n_left = 6'd1;
            default:             n_left = '0;
        endcase
    end

    assign w_idx = r_left[IDX_W-1:0] - 5'd1;

    // sample shifter, first sample from the top used bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_cmd.load) begin
            r_left <= n_left;
        end else if (i_cmd.step) begin
            r_left <= r_left - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= t_opcode'(i_opcode);
            r_val  <= i_operand_value;
            r_smp  <= i_line_samples;
            r_word <= '0;
        end else if (i_cmd.step) begin
            r_word <= {r_word[DATA_W-2:0], r_smp[w_idx]};
        end
    end

    // line levels after the held command
    always_comb begin
        n_clk_line = r_clk_line;
        n_dat_line = r_dat_line;
        n_sel_line = r_sel_line;
        n_dat_in   = r_dat_in;
        case (r_op)
            OP_START: begin
                n_clk_line = 1'b0;
                n_dat_line = 1'b1;
            end
            OP_STOP: begin
                n_clk_line = 1'b1;
                n_dat_line = 1'b1;
            end
            OP_XFER, OP_WRITE, OP_WRBIT: begin
                n_dat_line = r_val[0];
                n_dat_in   = 1'b0;
                n_clk_line = 1'b0;
            end
            OP_READ, OP_RDBIT: begin
                if (!r_three_wire) n_dat_in = 1'b1;
                n_clk_line = 1'b0;
            end
            OP_TICKS: begin
                if (r_val != '0) n_clk_line = 1'b0;
            end
            OP_DATA: begin
                n_dat_line = r_val[0];
                n_dat_in   = 1'b0;
            end
            OP_CLK: begin
                n_clk_line = r_val[0];
            end
            OP_CS: begin
                n_sel_line = r_val[0];
            end
            OP_SAMPLE: begin
                if (!r_three_wire) n_dat_in = 1'b1;
            end
            default: ;
        endcase
    end

    // commit line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_line <= 1'b0;
            r_dat_line <= 1'b0;
            r_sel_line <= 1'b0;
            r_dat_in   <= 1'b0;
        end else if (i_cmd.finish) begin
            r_clk_line <= n_clk_line;
            r_dat_line <= n_dat_line;
            r_sel_line <= n_sel_line;
            r_dat_in   <= n_dat_in;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_data <= r_word;
        end
    end

    assign o_sts.done      = (r_left == '0);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_read_data     = r_out_data;
    assign o_clock_level   = r_clk_line;
    assign o_data_level    = r_dat_line;
    assign o_select_level  = r_sel_line;
    assign o_data_released = r_dat_in;

    // checks
    `BSM_ASSERT_IMP(a_step_needs_bits, i_clk, i_rst_n, i_cmd.step, r_left != '0)
    `BSM_ASSERT_IMP(a_finish_needs_room, i_clk, i_rst_n, i_cmd.finish, !r_out_valid || i_out_ready)
    `BSM_ASSERT_NXT(a_finish_gives_result, i_clk, i_rst_n, i_cmd.finish, r_out_valid)
    `BSM_ASSERT_IMP(a_left_in_range, i_clk, i_rst_n, 1'b1, r_left <= MAX_BITS)

endmodule

`default_nettype wire

FILE: hdl/bitbang_serial_master_top.sv
// ----------------------------------------------------------------------------
// bitbang_serial_master_top
// Command-driven bit-bang serial master: sequencer plus datapath.
// ----------------------------------------------------------------------------
// The sample shifter takes one bit a cycle (n bits: the clamped bit_count for
// xfer and read, 1 for rdbit and sample, 0 otherwise), then the commit puts
// the line levels into the line state and the sampled word into the result
// register once the output is free. The input is ready again in the cycle
// after the commit. A new command is taken while the previous result beat
// still waits at the output, but its commit then waits until that beat has
// been taken. Configuration writes must be made only while the block is idle;
// the block itself does not enforce this. Speed and open_drain are held
// nowhere, as they change no logical level.
`default_nettype none

module bitbang_serial_master_top (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_wr_en,
    input  wire [bsm_pkg::CFGA_W-1:0]    i_cfg_index,
    input  wire [bsm_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire [bsm_pkg::OP_W-1:0]      i_opcode,
    input  wire [bsm_pkg::DATA_W-1:0]    i_operand_value,
    input  wire [bsm_pkg::DATA_W-1:0]    i_line_samples,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [bsm_pkg::DATA_W-1:0]   o_read_data,
    output logic                         o_clock_level,
    output logic                         o_data_level,
    output logic                         o_select_level,
    output logic                         o_data_released
);
    import bsm_pkg::*;

    t_bsm_cmd w_cmd;
    t_bsm_sts w_sts;

    // sequencer
    bsm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // datapath
    bsm_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_opcode        (i_opcode),
        .i_operand_value (i_operand_value),
        .i_line_samples  (i_line_samples),
        .i_out_ready     (i_out_ready),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_out_valid     (o_out_valid),
        .o_read_data     (o_read_data),
        .o_clock_level   (o_clock_level),
        .o_data_level    (o_data_level),
        .o_select_level  (o_select_level),
        .o_data_released (o_data_released)
    );

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bit-bang serial master. Commands go in over a
// valid/ready channel and each one gives one result beat with the sampled
// word and the line levels. A line-level predictor runs beside the block and
// every result beat is compared field by field. A short table of directed
// commands comes first, then random I2C frames, SPI frames and loose
// commands under several register settings, with random idling on both
// sides, one long output hold-off and one full drain mid-phase.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import bsm_pkg::*;

    // spare opcodes that must change nothing
    localparam logic [OP_W-1:0] OP_SPARE_LO = 4'd12;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 4'd15;

    localparam int unsigned PHASES       = 10;
    localparam int unsigned PHASE_CMDS   = 100;
    localparam int unsigned HOLD_PHASE   = 3;
    localparam int unsigned QUIET_PHASE  = 5;
    localparam int unsigned PAUSE_PHASE  = 6;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned SETTLE_WAIT  = 40;
    localparam int unsigned PRINT_LIMIT  = 40;
    localparam int unsigned DIRECTED_LEN = 25;

    // levels reported with each result beat
    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              clock_level;
        logic              data_level;
        logic              select_level;
        logic              data_released;
    } t_line_result;

    // one directed command, optionally with its result typed in
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] operand;
        logic [DATA_W-1:0] samples;
        logic              has_want;
        t_line_result      want;
    } t_cmd_row;

    // one register setting
    typedef struct packed {
        logic [CFG_W-1:0] bit_count;
        logic             three_wire;
        logic [1:0]       speed;
        logic             open_drain;
    } t_cfg_set;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [CFGA_W-1:0] cfg_index   = CFG_BIT_COUNT;
    logic [CFG_W-1:0]  cfg_data    = '0;
    logic              in_valid    = 1'b0;
    logic [OP_W-1:0]   in_opcode   = OP_START;
    logic [DATA_W-1:0] in_operand  = '0;
    logic [DATA_W-1:0] in_samples  = '0;
    logic              out_ready   = 1'b0;
    wire               in_ready;
    wire               out_valid;
    wire  [DATA_W-1:0] read_data;
    wire               clock_level;
    wire               data_level;
    wire               select_level;
    wire               data_released;

    // predictor copy of registers and line state
    logic [CFG_W-1:0]  cfg_bit_count  = 6'd8;
    logic              cfg_three_wire = 1'b1;
    logic [1:0]        cfg_speed      = 2'd0;
    logic              cfg_open_drain = 1'b0;
    logic              line_clock     = 1'b0;
    logic              line_data      = 1'b0;
    logic              line_select    = 1'b0;
    logic              line_released  = 1'b0;

    t_line_result      expected_beats [$];
    t_cmd_row          directed_cmds [DIRECTED_LEN];
    t_cfg_set          phase_cfgs [PHASES];
    int unsigned       fail_count   = 0;
    int unsigned       cmds_issued  = 0;
    bit                quiet        = 1'b0;
    bit                hold_request = 1'b0;

    bitbang_serial_master_top u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_opcode        (in_opcode),
        .i_operand_value (in_operand),
        .i_line_samples  (in_samples),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_read_data     (read_data),
        .o_clock_level   (clock_level),
        .o_data_level    (data_level),
        .o_select_level  (select_level),
        .o_data_released (data_released)
    );

    // clock
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run limit
    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        fail_count++;
        if (fail_count <= PRINT_LIMIT)
            $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    endtask

    // line levels after one command, advancing the predicted state
    function automatic t_line_result predict_line_levels(input logic [OP_W-1:0] op,
                                                         input logic [DATA_W-1:0] operand,
                                                         input logic [DATA_W-1:0] samples);
        t_line_result res;
        int unsigned  nbits;
        logic [DATA_W-1:0] mask;
        // clamp the transfer length into 1..32
        if (cfg_bit_count == 0)
            nbits = 1;
        else if (cfg_bit_count > 32)
            nbits = 32;
        else
            nbits = 32'(cfg_bit_count);
        mask = (nbits >= 32) ? '1 : ((DATA_W'(1) << nbits) - 1);
        res.read_data = '0;
        case (op)
            OP_START: begin
                line_clock = 1'b0;
                line_data  = 1'b1;
            end
            OP_STOP: begin
                line_clock = 1'b1;
                line_data  = 1'b1;
            end
            OP_XFER, OP_WRITE: begin
                line_data     = operand[0];
                line_released = 1'b0;
                line_clock    = 1'b0;
                if (op == OP_XFER)
                    res.read_data = samples & mask;
            end
            OP_READ, OP_RDBIT: begin
                if (!cfg_three_wire)
                    line_released = 1'b1;
                line_clock    = 1'b0;
                res.read_data = (op == OP_RDBIT) ? DATA_W'(samples[0]) : (samples & mask);
            end
            OP_WRBIT: begin
                line_data     = operand[0];
                line_released = 1'b0;
                line_clock    = 1'b0;
            end
            OP_TICKS: begin
                // a zero count leaves the clock alone
                if (operand != 0)
                    line_clock = 1'b0;
            end
            OP_DATA: begin
                line_data     = operand[0];
                line_released = 1'b0;
            end
            OP_CLK:    line_clock  = operand[0];
            OP_CS:     line_select = operand[0];
            OP_SAMPLE: begin
                if (!cfg_three_wire)
                    line_released = 1'b1;
                res.read_data = DATA_W'(samples[0]);
            end
            default: ;
        endcase
        res.clock_level   = line_clock;
        res.data_level    = line_data;
        res.select_level  = line_select;
        res.data_released = line_released;
        return res;
    endfunction

    // offer one command beat and hold it until taken
    task automatic send_command(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] operand,
                                input logic [DATA_W-1:0] samples);
        while (!quiet && $urandom_range(0, 99) < 9) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_opcode  <= op;
        in_operand <= operand;
        in_samples <= samples;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic issue(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] operand,
                         input logic [DATA_W-1:0] samples);
        send_command(op, operand, samples);
        expected_beats.push_back(predict_line_levels(op, operand, samples));
        cmds_issued++;
    endtask

    // stop offering and wait for every outstanding result beat
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
    endtask

    task automatic apply_config(input t_cfg_set s);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_BIT_COUNT;
        cfg_data  <= s.bit_count;
        @(posedge clk);
        cfg_index <= CFG_THREE_WIRE;
        cfg_data  <= CFG_W'(s.three_wire);
        @(posedge clk);
        cfg_index <= CFG_SPEED;
        cfg_data  <= CFG_W'(s.speed);
        @(posedge clk);
        cfg_index <= CFG_OPEN_DRAIN;
        cfg_data  <= CFG_W'(s.open_drain);
        @(posedge clk);
        cfg_wr_en      <= 1'b0;
        cfg_bit_count  = s.bit_count;
        cfg_three_wire = s.three_wire;
        cfg_speed      = s.speed;
        cfg_open_drain = s.open_drain;
    endtask

    // random traffic: mostly well-formed frames, some loose commands
    task automatic run_phase(input int unsigned count);
        int unsigned first;
        int unsigned pick;
        int unsigned k;
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] operand;
        first = cmds_issued;
        while (cmds_issued - first < count) begin
            pick = $urandom_range(0, 19);
            if (pick < 8) begin
                // i2c frame: start, address, ack, payload bytes, stop
                issue(OP_START, $urandom, $urandom);
                issue(OP_WRITE, $urandom, $urandom);
                issue(OP_RDBIT, $urandom, $urandom);
                k = $urandom_range(1, 3);
                repeat (k) begin
                    if ($urandom_range(0, 1)) begin
                        issue(OP_WRITE, $urandom, $urandom);
                        issue(OP_RDBIT, $urandom, $urandom);
                    end else begin
                        issue(OP_READ, $urandom, $urandom);
                        issue(OP_WRBIT, $urandom, $urandom);
                    end
                end
                issue(OP_STOP, $urandom, $urandom);
            end else if (pick < 15) begin
                // spi frame: select low, words, select high
                issue(OP_CS, $urandom & ~DATA_W'(1), $urandom);
                k = $urandom_range(1, 4);
                repeat (k) begin
                    case ($urandom_range(0, 3))
                        0:       op = OP_WRITE;
                        1:       op = OP_READ;
                        default: op = OP_XFER;
                    endcase
                    issue(op, $urandom, $urandom);
                end
                issue(OP_CS, $urandom | DATA_W'(1), $urandom);
            end else begin
                // loose commands, spare opcodes included
                k = $urandom_range(1, 6);
                repeat (k) begin
                    op = OP_W'($urandom_range(0, 15));
                    operand = $urandom;
                    if (op == OP_TICKS) begin
                        case ($urandom_range(0, 4))
                            0: operand = '0;
                            1: operand = $urandom_range(1, 300);
                            2: operand = 32'h0000_FFFF;
                            3: operand = 32'h0001_0000 + $urandom_range(0, 1000);
                            default: ;
                        endcase
                    end
                    issue(op, operand, $urandom);
                end
            end
        end
    endtask

    // result beat checker
    always @(posedge clk) begin : check_beats
        t_line_result want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_beats.size() == 0) begin
                report_mismatch("result beat with nothing expected", read_data, '0);
            end else begin
                want = expected_beats.pop_front();
                if (read_data !== want.read_data)
                    report_mismatch("read_data", read_data, want.read_data);
                if (clock_level !== want.clock_level)
                    report_mismatch("clock_level", clock_level, want.clock_level);
                if (data_level !== want.data_level)
                    report_mismatch("data_level", data_level, want.data_level);
                if (select_level !== want.select_level)
                    report_mismatch("select_level", select_level, want.select_level);
                if (data_released !== want.data_released)
                    report_mismatch("data_released", data_released, want.data_released);
            end
        end
    end

    // receiver: random ready, plus one long hold-off on request
    initial begin : receiver
        forever begin
            @(posedge clk);
            if (hold_request) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end else begin
                out_ready <= quiet || ($urandom_range(0, 99) >= 9);
            end
        end
    end

    // stimulus
    initial begin : stimulus
        t_line_result predicted;
        // directed commands at the reset settings
        directed_cmds = '{
            '{OP_READ,    32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{32'h0000_00FF, 1'b0, 1'b0, 1'b0, 1'b0}},
            '{OP_START,   32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0, 1'b0, 1'b1, 1'b0, 1'b0}},
            '{OP_STOP,    32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0, 1'b1, 1'b1, 1'b0, 1'b0}},
            '{OP_XFER,    32'hFFFF_FFFE, 32'hA5A5_A5A5, 1'b1, '{32'h0000_00A5, 1'b0, 1'b0, 1'b0, 1'b0}},
            '{OP_WRITE,   32'h0000_0001, 32'hFFFF_FFFF, 1'b1, '{32'h0, 1'b0, 1'b1, 1'b0, 1'b0}},
            '{OP_WRITE,   32'hFFFF_FF00, 32'h0000_0000, 1'b0, '0},
            '{OP_RDBIT,   32'h0000_0000, 32'hFFFF_FFFE, 1'b0, '0},
            '{OP_RDBIT,   32'h0000_0000, 32'h0000_0001, 1'b0, '0},
            '{OP_WRBIT,   32'h0000_0001, 32'h0000_0000, 1'b0, '0},
            '{OP_WRBIT,   32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0, '0},
            '{OP_CLK,     32'h0000_0001, 32'h0000_0000, 1'b0, '0},
            '{OP_TICKS,   32'h0000_0000, 32'h0000_0000, 1'b0, '0},
            '{OP_TICKS,   32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
            '{OP_CLK,     32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
            '{OP_TICKS,   32'h0001_0000, 32'h0000_0000, 1'b0, '0},
            '{OP_CS,      32'h0000_0001, 32'h0000_0000, 1'b0, '0},
            '{OP_CS,      32'hFFFF_FFFE, 32'h0000_0000, 1'b0, '0},
            '{OP_SAMPLE,  32'h0000_0000, 32'hFFFF_FFFF, 1'b0, '0},
            '{OP_SAMPLE,  32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0, '0},
            '{OP_DATA,    32'h8000_0000, 32'h0000_0000, 1'b0, '0},
            '{OP_DATA,    32'h0000_0001, 32'h0000_0000, 1'b0, '0},
            '{OP_SPARE_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'h0, 1'b0, 1'b1, 1'b0, 1'b0}},
            '{OP_SPARE_HI, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, '0},
            '{OP_XFER,    32'h0000_0000, 32'h0000_0000, 1'b0, '0},
            '{OP_READ,    32'hFFFF_FFFF, 32'h0000_0100, 1'b0, '0}
        };
        // settings per random phase, extremes and out-of-range counts among them
        phase_cfgs = '{
            '{6'd32, 1'b0, 2'd3, 1'b1},
            '{6'd1,  1'b1, 2'd2, 1'b0},
            '{6'd0,  1'b0, 2'd1, 1'b1},
            '{6'd63, 1'b1, 2'd3, 1'b0},
            '{6'd33, 1'b0, 2'd0, 1'b1},
            '{6'd16, 1'b1, 2'd1, 1'b0},
            '{6'd5,  1'b0, 2'd2, 1'b0},
            '{6'd12, 1'b1, 2'd0, 1'b1},
            '{6'd8,  1'b0, 2'd3, 1'b0},
            '{6'd24, 1'b1, 2'd2, 1'b1}
        };
        phase_cfgs[6].bit_count  = CFG_W'($urandom_range(0, 63));
        phase_cfgs[6].speed      = 2'($urandom_range(0, 3));
        phase_cfgs[7].bit_count  = CFG_W'($urandom_range(0, 63));
        phase_cfgs[7].three_wire = 1'($urandom_range(0, 1));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed table, typed results where given, predictor otherwise
        for (int unsigned r = 0; r < DIRECTED_LEN; r++) begin
            send_command(directed_cmds[r].op, directed_cmds[r].operand,
                         directed_cmds[r].samples);
            predicted = predict_line_levels(directed_cmds[r].op, directed_cmds[r].operand,
                                            directed_cmds[r].samples);
            expected_beats.push_back(directed_cmds[r].has_want ? directed_cmds[r].want
                                                               : predicted);
        end
        drain_results();

        // random phases, each under its own register setting
        for (int unsigned p = 0; p < PHASES; p++) begin
            apply_config(phase_cfgs[p]);
            if (p == HOLD_PHASE)
                hold_request = 1'b1;
            quiet = (p == QUIET_PHASE);
            if (p == PAUSE_PHASE) begin
                run_phase(PHASE_CMDS / 2);
                drain_results();
            end
            run_phase(PHASE_CMDS);
            drain_results();
            quiet = 1'b0;
        end

        // let any stray beat show up
        repeat (SETTLE_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

FILE: bitbang_serial_master_top.f
+incdir+hdl
hdl/bsm_pkg.sv
hdl/bsm_ctrl.sv
hdl/bsm_dpath.sv
hdl/bitbang_serial_master_top.sv
sim/testbench.sv
